### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is held.
`define BRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset.
`define BRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### rtl/core/brs_pkg.sv
`timescale 1ns / 1ps
package brs_pkg;

    localparam int NEURONS     = 128;
    localparam int SYMBOLS     = 256;
    localparam int WEIGHT_BITS = 16;

    // Bias, input weight and NEURONS recurrent terms never overflow this.
    localparam int ACC_BITS  = WEIGHT_BITS + $clog2(NEURONS + 2) + 1;
    localparam int REC_AW    = $clog2(NEURONS);
    localparam int SYM_AW    = $clog2(SYMBOLS + 1);
    localparam int LANE_BITS = NEURONS * WEIGHT_BITS;
    localparam int SHOW_BITS = (NEURONS > 128) ? NEURONS : 128;
    localparam int POP_GROUP = 8;
    localparam int POP_STEPS = (NEURONS + POP_GROUP - 1) / POP_GROUP;
    localparam int POP_BITS  = POP_STEPS * POP_GROUP;
    localparam int POP_AW    = $clog2(POP_STEPS);
    localparam int FLIP_BITS = $clog2(NEURONS + 1);

    localparam logic [2:0] OP_REC_W = 3'd0;
    localparam logic [2:0] OP_IN_W  = 3'd1;
    localparam logic [2:0] OP_BIAS  = 3'd2;
    localparam logic [2:0] OP_STATE = 3'd3;
    localparam logic [2:0] OP_STEP  = 3'd4;

    typedef struct packed {
        logic [2:0]         op;
        logic [6:0]         row;
        logic [7:0]         column;
        logic signed [15:0] weight;
        logic               chunk_select;
        logic [63:0]        chunk_bits;
        logic [7:0]         input_byte;
    } t_in_word;

    typedef struct packed {
        logic [63:0] state_chunk;
        logic        chunk_index;
        logic [7:0]  flip_count;
        logic        last;
    } t_out_word;

    // Sign-extend the 16-bit value, then keep the stored width.
    function automatic logic [WEIGHT_BITS-1:0] fit_weight(input logic signed [15:0] w);
        logic signed [31:0] ext;
        ext = 32'(w);
        return ext[WEIGHT_BITS-1:0];
    endfunction

    function automatic logic [3:0] popcount8(input logic [POP_GROUP-1:0] v);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < POP_GROUP; i++) begin
            s = s + 4'(v[i]);
        end
        return s;
    endfunction

endpackage

### rtl/core/brs_if.sv
`timescale 1ns / 1ps
interface brs_in_if;
    import brs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface brs_out_if;
    import brs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/brs_ram.sv
`timescale 1ns / 1ps
module brs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_mask,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int b = 0; b < WIDTH; b++) begin
                if (i_wr_mask[b]) begin
                    r_mem[i_wr_addr][b] <= i_wr_data[b];
                end
            end
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/binary_recurrent_step.sv
// Binary recurrent step: a network of NEURONS one-bit neurons with signed Q8.8 weights held in
// two column-wide memories, one word per source neuron for the recurrent weights and one word
// per input symbol (plus one word for the biases) for the input weights. A step reads the bias
// word, the input word and then one recurrent column per cycle into NEURONS parallel
// accumulators, then tallies the flip count eight neurons a cycle. It passes through the bias,
// input, accumulate, sign and tally states before it offers its two 64-bit state words, chunk 0
// first; a new input word is taken only once both have left, so a step is not taken while the
// last one is still in flight. The hidden state clears to zero at reset; the weight memories
// hold nothing until written and need no clearing pass.
`timescale 1ns / 1ps
module binary_recurrent_step (
    input logic       i_clk,
    input logic       i_rst_n,
    brs_in_if.sink    i_in,
    brs_out_if.source o_out
);
    import brs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BIAS, S_INW, S_ACC, S_SIGN, S_POP, S_OUT0, S_OUT1
    } t_state;

    localparam logic [SYM_AW-1:0] BIAS_ADDR = SYM_AW'(SYMBOLS);

    t_state                     r_state;
    logic [REC_AW-1:0]          r_col;
    logic [POP_AW-1:0]          r_grp;
    logic [SYM_AW-1:0]          r_sym;
    logic                       r_sym_ok;
    logic [NEURONS-1:0]         r_hidden;
    logic [NEURONS-1:0]         r_diff;
    logic [FLIP_BITS-1:0]       r_flips;
    logic signed [ACC_BITS-1:0] r_acc [NEURONS];
    logic signed [ACC_BITS-1:0] n_acc [NEURONS];
    logic signed [ACC_BITS-1:0] rec_ext [NEURONS];
    logic signed [ACC_BITS-1:0] in_ext [NEURONS];

    logic                  accept;
    logic                  row_ok;
    logic                  rec_wr;
    logic                  in_wr;
    logic [LANE_BITS-1:0]  lane_mask;
    logic [LANE_BITS-1:0]  wr_data;
    logic [SYM_AW-1:0]     in_wr_addr;
    logic [SYM_AW-1:0]     in_rd_addr;
    logic [REC_AW-1:0]     rec_rd_addr;
    logic [LANE_BITS-1:0]  rec_rd_data;
    logic [LANE_BITS-1:0]  in_rd_data;
    logic                  hid_bit;
    logic [POP_BITS-1:0]   diff_pad;
    logic [POP_GROUP-1:0]  diff_grp;
    logic [SHOW_BITS-1:0]  show_bits;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Write decode: out-of-range rows and columns are dropped.
    assign row_ok = 32'(i_in.data.row) < NEURONS;
    assign rec_wr = accept && (i_in.data.op == OP_REC_W) && row_ok
                    && (32'(i_in.data.column) < NEURONS);
    assign in_wr  = accept && row_ok
                    && (((i_in.data.op == OP_IN_W) && (32'(i_in.data.column) < SYMBOLS))
                        || (i_in.data.op == OP_BIAS));
    assign in_wr_addr = (i_in.data.op == OP_BIAS) ? BIAS_ADDR : SYM_AW'(i_in.data.column);
    assign wr_data = {NEURONS{fit_weight(i_in.data.weight)}};

    always_comb begin
        for (int l = 0; l < NEURONS; l++) begin
            lane_mask[l*WEIGHT_BITS +: WEIGHT_BITS] = {WEIGHT_BITS{32'(i_in.data.row) == l}};
        end
    end

    // The bias word is fetched in the accept cycle, the input word in the cycle after.
    assign in_rd_addr  = (r_state == S_IDLE) ? BIAS_ADDR : r_sym;
    assign rec_rd_addr = (r_state == S_INW) ? '0 : REC_AW'(r_col + 1'b1);

    brs_ram #(
        .WIDTH (LANE_BITS),
        .DEPTH (NEURONS)
    ) u_rec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rec_wr),
        .i_wr_addr (REC_AW'(i_in.data.column)),
        .i_wr_mask (lane_mask),
        .i_wr_data (wr_data),
        .i_rd_addr (rec_rd_addr),
        .o_rd_data (rec_rd_data)
    );

    brs_ram #(
        .WIDTH (LANE_BITS),
        .DEPTH (SYMBOLS + 1)
    ) u_in_ram (
        .i_clk     (i_clk),
        .i_wr_en   (in_wr),
        .i_wr_addr (in_wr_addr),
        .i_wr_mask (lane_mask),
        .i_wr_data (wr_data),
        .i_rd_addr (in_rd_addr),
        .o_rd_data (in_rd_data)
    );

    assign hid_bit = r_hidden[r_col];

    always_comb begin
        for (int l = 0; l < NEURONS; l++) begin
            rec_ext[l] = ACC_BITS'($signed(rec_rd_data[l*WEIGHT_BITS +: WEIGHT_BITS]));
            in_ext[l]  = ACC_BITS'($signed(in_rd_data[l*WEIGHT_BITS +: WEIGHT_BITS]));
            n_acc[l]   = r_acc[l];
            unique case (r_state)
                S_BIAS: begin
                    n_acc[l] = in_ext[l];
                end
                S_INW: begin
                    if (r_sym_ok) begin
                        n_acc[l] = r_acc[l] + in_ext[l];
                    end
                end
                S_ACC: begin
                    // A set source bit adds its weight, a clear one subtracts it.
                    n_acc[l] = hid_bit ? (r_acc[l] + rec_ext[l]) : (r_acc[l] - rec_ext[l]);
                end
                default: begin
                end
            endcase
        end
    end

    assign diff_pad = POP_BITS'(r_diff);
    assign diff_grp = diff_pad[32'(r_grp) * POP_GROUP +: POP_GROUP];

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hidden <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_in.data.op == OP_STATE)) begin
                        for (int n = 0; n < NEURONS; n++) begin
                            if ((n < 128) && ((n >= 64) == i_in.data.chunk_select)) begin
                                r_hidden[n] <= i_in.data.chunk_bits[n & 63];
                            end
                        end
                    end else if (accept && (i_in.data.op == OP_STEP)) begin
                        r_sym    <= SYM_AW'(i_in.data.input_byte);
                        r_sym_ok <= 32'(i_in.data.input_byte) < SYMBOLS;
                        r_state  <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    r_state <= S_INW;
                end
                S_INW: begin
                    r_col   <= '0;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_col <= REC_AW'(r_col + 1'b1);
                    if (r_col == REC_AW'(NEURONS - 1)) begin
                        r_state <= S_SIGN;
                    end
                end
                S_SIGN: begin
                    for (int l = 0; l < NEURONS; l++) begin
                        r_hidden[l] <= !r_acc[l][ACC_BITS-1];
                        r_diff[l]   <= (!r_acc[l][ACC_BITS-1]) ^ r_hidden[l];
                    end
                    r_flips <= '0;
                    r_grp   <= '0;
                    r_state <= S_POP;
                end
                S_POP: begin
                    r_flips <= r_flips + FLIP_BITS'(popcount8(diff_grp));
                    r_grp   <= POP_AW'(r_grp + 1'b1);
                    if (r_grp == POP_AW'(POP_STEPS - 1)) begin
                        r_state <= S_OUT0;
                    end
                end
                S_OUT0: begin
                    if (o_out.ready) begin
                        r_state <= S_OUT1;
                    end
                end
                S_OUT1: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign show_bits = SHOW_BITS'(r_hidden);

    assign o_out.valid            = (r_state == S_OUT0) || (r_state == S_OUT1);
    assign o_out.data.chunk_index = (r_state == S_OUT1);
    assign o_out.data.last        = (r_state == S_OUT1);
    assign o_out.data.state_chunk = (r_state == S_OUT1) ? show_bits[127:64] : show_bits[63:0];
    assign o_out.data.flip_count  = (32'(r_flips) > 32'd255) ? 8'hFF : 8'(r_flips);

endmodule

### rtl/core/brs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [2:0] i_in_op,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_chunk_index,
    input logic       i_out_last,
    input logic [7:0] i_out_flip_count
);
    import brs_pkg::*;

    `BRS_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_out_valid, "output word valid after reset")

    `BRS_ASSERT(a_busy_while_out, i_out_valid |-> !i_in_ready, "input taken while a word waits")

    `BRS_ASSERT(a_index_last, i_out_valid |-> (i_out_chunk_index == i_out_last), "chunk index and last disagree")

    // The second word follows at once and repeats the distance of the first.
    `BRS_ASSERT(a_pair, (i_out_valid && i_out_ready && !i_out_last) |=> (i_out_valid && i_out_last && (i_out_flip_count == $past(i_out_flip_count))), "second state word missing or differs")

    `BRS_ASSERT(a_step_busy, (i_in_valid && i_in_ready && (i_in_op == OP_STEP)) |=> (!i_out_valid && !i_in_ready), "step did not start its pass")

endmodule

bind binary_recurrent_step brs_checker u_brs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_op           (i_in.data.op),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_chunk_index (o_out.data.chunk_index),
    .i_out_last        (o_out.data.last),
    .i_out_flip_count  (o_out.data.flip_count)
);
